// ----- rtl/rilp_pkg.sv -----
// Shared types, constants and the tag classifier of the RIFF INFO list parser.
package rilp_pkg;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_HDR  = 3'd1,
    PH_ID   = 3'd2,
    PH_LEN  = 3'd3,
    PH_DATA = 3'd4,
    PH_PAD  = 3'd5,
    PH_DEAD = 3'd6
  } phase_e;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadSig = 2'd1;
  localparam logic [1:0] StatusTrunc  = 2'd2;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  localparam logic [31:0] SigList = "LIST";

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] Lead2Lo    = 8'hC0;
  localparam logic [7:0] Lead2Hi    = 8'hDF;
  localparam logic [7:0] Lead3Lo    = 8'hE0;
  localparam logic [7:0] Lead3Hi    = 8'hEF;
  localparam logic [7:0] Lead4Lo    = 8'hF0;
  localparam logic [7:0] Lead4Hi    = 8'hF7;
  localparam logic [7:0] ContLo     = 8'h80;
  localparam logic [7:0] ContHi     = 8'hBF;

  localparam logic [4:0] TagUnknown = 5'd0;
  localparam logic [4:0] TagArtist  = 5'd1;
  localparam logic [4:0] TagTitle   = 5'd2;
  localparam logic [4:0] TagAlbum   = 5'd3;
  localparam logic [4:0] TagYear    = 5'd4;
  localparam logic [4:0] TagGenre   = 5'd5;
  localparam logic [4:0] TagRating  = 5'd6;
  localparam logic [4:0] TagComment = 5'd7;
  localparam logic [4:0] TagLabel   = 5'd8;
  localparam logic [4:0] TagTrack   = 5'd9;
  localparam logic [4:0] TagMusic   = 5'd10;
  localparam logic [4:0] TagWriter  = 5'd11;
  localparam logic [4:0] TagProd    = 5'd12;
  localparam logic [4:0] TagEng     = 5'd13;
  localparam logic [4:0] TagCopy    = 5'd14;
  localparam logic [4:0] TagSource  = 5'd15;
  localparam logic [4:0] TagCount   = 5'd16;
  localparam logic [4:0] TagUrl     = 5'd17;
  localparam logic [4:0] TagToc     = 5'd18;

  // One queue entry holds everything a single input byte produces.
  typedef struct packed {
    logic       has_data;
    logic [4:0] tag_code;
    logic [7:0] value_byte;
    logic       item_end;
    logic       text_is_utf8;
    logic       has_status;
    logic [1:0] status;
  } entry_t;

  function automatic logic [7:0] sig_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = SigList[31:24];
      2'd1:    c = SigList[23:16];
      2'd2:    c = SigList[15:8];
      default: c = SigList[7:0];
    endcase
    return c;
  endfunction

  function automatic logic [4:0] classify(input logic [31:0] id);
    logic [4:0] t;
    case (id)
      "IART":  t = TagArtist;
      "INAM":  t = TagTitle;
      "IPRD":  t = TagAlbum;
      "ICRD":  t = TagYear;
      "IGNR":  t = TagGenre;
      "IRTD":  t = TagRating;
      "ICMT":  t = TagComment;
      "IDST":  t = TagLabel;
      "TORG":  t = TagLabel;
      "IPRT":  t = TagTrack;
      "ITRK":  t = TagTrack;
      "TRCK":  t = TagTrack;
      "IMUS":  t = TagMusic;
      "IWRI":  t = TagWriter;
      "IPRO":  t = TagProd;
      "IENG":  t = TagEng;
      "ICOP":  t = TagCopy;
      "ISRF":  t = TagSource;
      "ICNT":  t = TagCount;
      "IURL":  t = TagUrl;
      "ITOC":  t = TagToc;
      default: t = TagUnknown;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/rilp_front.sv -----
// Front stage: walks the chunk structure byte by byte and builds queue entries.
module rilp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                buf_end_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output rilp_pkg::entry_t    q_entry_o
);

  rilp_pkg::phase_e phase_q, phase_d;
  logic [2:0]  field_count_q, field_count_d;
  logic [23:0] id_shift_q, id_shift_d;
  logic [30:0] remaining_len_q, remaining_len_d;
  logic        odd_pad_q, odd_pad_d;
  logic [4:0]  current_tag_q, current_tag_d;
  logic        sig_bad_q, sig_bad_d;
  logic [1:0]  utf_pending_q, utf_pending_d;
  logic        utf_seen_high_q, utf_seen_high_d;
  logic        utf_failed_q, utf_failed_d;
  logic        utf_stopped_q, utf_stopped_d;
  logic        accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= rilp_pkg::PH_SIG;
      field_count_q   <= '0;
      id_shift_q      <= '0;
      remaining_len_q <= '0;
      odd_pad_q       <= 1'b0;
      current_tag_q   <= '0;
      sig_bad_q       <= 1'b0;
      utf_pending_q   <= '0;
      utf_seen_high_q <= 1'b0;
      utf_failed_q    <= 1'b0;
      utf_stopped_q   <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      field_count_q   <= field_count_d;
      id_shift_q      <= id_shift_d;
      remaining_len_q <= remaining_len_d;
      odd_pad_q       <= odd_pad_d;
      current_tag_q   <= current_tag_d;
      sig_bad_q       <= sig_bad_d;
      utf_pending_q   <= utf_pending_d;
      utf_seen_high_q <= utf_seen_high_d;
      utf_failed_q    <= utf_failed_d;
      utf_stopped_q   <= utf_stopped_d;
    end
  end

  always_comb begin
    logic [7:0]  b;
    logic [31:0] full_len;
    logic        end_item;
    logic [1:0]  st;

    b               = data_byte_i;
    full_len        = {b, remaining_len_q[23:0]};
    end_item        = (remaining_len_q <= 31'd1);
    st              = rilp_pkg::StatusOk;
    phase_d         = phase_q;
    field_count_d   = field_count_q;
    id_shift_d      = id_shift_q;
    remaining_len_d = remaining_len_q;
    odd_pad_d       = odd_pad_q;
    current_tag_d   = current_tag_q;
    sig_bad_d       = sig_bad_q;
    utf_pending_d   = utf_pending_q;
    utf_seen_high_d = utf_seen_high_q;
    utf_failed_d    = utf_failed_q;
    utf_stopped_d   = utf_stopped_q;
    q_entry_o       = '0;

    if (accept) begin
      case (phase_q)
        rilp_pkg::PH_SIG: begin
          sig_bad_d     = sig_bad_q || (b != rilp_pkg::sig_char(field_count_q[1:0]));
          field_count_d = field_count_q + 3'd1;
          if (field_count_q == 3'd3) begin
            field_count_d = '0;
            phase_d       = sig_bad_d ? rilp_pkg::PH_DEAD : rilp_pkg::PH_HDR;
          end
        end
        rilp_pkg::PH_HDR: begin
          field_count_d = field_count_q + 3'd1;
          if (field_count_q == 3'd7) begin
            field_count_d = '0;
            phase_d       = rilp_pkg::PH_ID;
          end
        end
        rilp_pkg::PH_ID: begin
          id_shift_d    = {id_shift_q[15:0], b};
          field_count_d = field_count_q + 3'd1;
          if (field_count_q == 3'd3) begin
            field_count_d   = '0;
            current_tag_d   = rilp_pkg::classify({id_shift_q, b});
            remaining_len_d = '0;
            phase_d         = rilp_pkg::PH_LEN;
          end
        end
        rilp_pkg::PH_LEN: begin
          field_count_d = field_count_q + 3'd1;
          case (field_count_q[1:0])
            2'd0:    remaining_len_d[7:0]   = b;
            2'd1:    remaining_len_d[15:8]  = b;
            2'd2:    remaining_len_d[23:16] = b;
            default: begin
              field_count_d = '0;
              if (full_len[31] || (full_len[30:0] == 31'd0)) begin
                remaining_len_d = '0;
                phase_d         = rilp_pkg::PH_ID;
              end else begin
                remaining_len_d = full_len[30:0];
                odd_pad_d       = full_len[0];
                utf_pending_d   = '0;
                utf_seen_high_d = 1'b0;
                utf_failed_d    = 1'b0;
                utf_stopped_d   = 1'b0;
                phase_d         = rilp_pkg::PH_DATA;
              end
            end
          endcase
        end
        rilp_pkg::PH_DATA: begin
          if (!utf_stopped_q) begin
            if (b == 8'd0) begin
              if (utf_pending_q != 2'd0) begin
                utf_failed_d = 1'b1;
              end
              utf_pending_d = '0;
              utf_stopped_d = 1'b1;
            end else if (utf_pending_q != 2'd0) begin
              if (b inside {[rilp_pkg::ContLo:rilp_pkg::ContHi]}) begin
                utf_pending_d = utf_pending_q - 2'd1;
              end else begin
                utf_failed_d  = 1'b1;
                utf_pending_d = '0;
                utf_stopped_d = 1'b1;
              end
            end else if (b > rilp_pkg::AsciiMax) begin
              utf_seen_high_d = 1'b1;
              if (b inside {[rilp_pkg::Lead2Lo:rilp_pkg::Lead2Hi]}) begin
                utf_pending_d = 2'd1;
              end else if (b inside {[rilp_pkg::Lead3Lo:rilp_pkg::Lead3Hi]}) begin
                utf_pending_d = 2'd2;
              end else if (b inside {[rilp_pkg::Lead4Lo:rilp_pkg::Lead4Hi]}) begin
                utf_pending_d = 2'd3;
              end else begin
                utf_failed_d  = 1'b1;
                utf_stopped_d = 1'b1;
              end
            end
          end
          remaining_len_d         = end_item ? 31'd0 : remaining_len_q - 31'd1;
          q_entry_o.has_data      = 1'b1;
          q_entry_o.tag_code      = current_tag_q;
          q_entry_o.value_byte    = b;
          q_entry_o.item_end      = end_item;
          q_entry_o.text_is_utf8  = end_item && utf_seen_high_d && !utf_failed_d &&
                                    (utf_pending_d == 2'd0);
          if (end_item) begin
            phase_d = odd_pad_q ? rilp_pkg::PH_PAD : rilp_pkg::PH_ID;
          end
        end
        rilp_pkg::PH_PAD: begin
          phase_d = rilp_pkg::PH_ID;
        end
        default: begin
        end
      endcase

      if (buf_end_i) begin
        if (phase_d inside {rilp_pkg::PH_SIG, rilp_pkg::PH_DEAD}) begin
          st = rilp_pkg::StatusBadSig;
        end else if ((phase_d == rilp_pkg::PH_ID && field_count_d != 3'd0) ||
                     (phase_d inside {rilp_pkg::PH_LEN, rilp_pkg::PH_DATA})) begin
          st = rilp_pkg::StatusTrunc;
        end
        q_entry_o.has_status = 1'b1;
        q_entry_o.status     = st;
        phase_d         = rilp_pkg::PH_SIG;
        field_count_d   = '0;
        id_shift_d      = '0;
        remaining_len_d = '0;
        odd_pad_d       = 1'b0;
        current_tag_d   = '0;
        sig_bad_d       = 1'b0;
        utf_pending_d   = '0;
        utf_seen_high_d = 1'b0;
        utf_failed_d    = 1'b0;
        utf_stopped_d   = 1'b0;
      end
    end
  end

  assign q_push_o = accept && (q_entry_o.has_data || q_entry_o.has_status);

  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_entry_o.has_status) |-> (accept && buf_end_i))
    else $error("Status entry pushed without an end-of-buffer byte.");

  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && buf_end_i) |=> (phase_q == rilp_pkg::PH_SIG && field_count_q == 3'd0))
    else $error("Parser did not restart after the end of the buffer.");

  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_entry_o.has_data) |-> (phase_q == rilp_pkg::PH_DATA))
    else $error("Payload entry pushed outside the payload phase.");

endmodule

// ----- rtl/rilp_fifo.sv -----
// Small entry queue that decouples the parsing front stage from the output stage.
module rilp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rilp_pkg::entry_t wdata_i,
  input  logic             pop_i,
  output rilp_pkg::entry_t rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rilp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("Pop from an empty queue.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("Queue count beyond its depth.");

endmodule

// ----- rtl/rilp_back.sv -----
// Back stage: expands queue entries into result items behind an output register.
module rilp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rilp_pkg::entry_t q_entry_i,
  input  logic             q_empty_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             kind_o,
  output logic [4:0]       tag_code_o,
  output logic [7:0]       value_byte_o,
  output logic             item_end_o,
  output logic             text_is_utf8_o,
  output logic [1:0]       status_o,
  output logic             run_last_o
);

  logic       valid_q, valid_d;
  logic       kind_q, kind_d;
  logic [4:0] tag_q, tag_d;
  logic [7:0] value_q, value_d;
  logic       item_end_q, item_end_d;
  logic       utf8_q, utf8_d;
  logic [1:0] status_q, status_d;
  logic       run_last_q, run_last_d;
  logic       sec_q, sec_d;
  logic [1:0] sec_status_q, sec_status_d;
  logic       load;

  assign load    = !valid_q || out_ready_i;
  assign q_pop_o = load && !sec_q && !q_empty_i;

  always_comb begin
    valid_d      = valid_q;
    kind_d       = kind_q;
    tag_d        = tag_q;
    value_d      = value_q;
    item_end_d   = item_end_q;
    utf8_d       = utf8_q;
    status_d     = status_q;
    run_last_d   = run_last_q;
    sec_d        = sec_q;
    sec_status_d = sec_status_q;
    if (load) begin
      if (sec_q) begin
        valid_d    = 1'b1;
        kind_d     = rilp_pkg::KindStatus;
        tag_d      = '0;
        value_d    = '0;
        item_end_d = 1'b0;
        utf8_d     = 1'b0;
        status_d   = sec_status_q;
        run_last_d = 1'b1;
        sec_d      = 1'b0;
      end else if (!q_empty_i) begin
        valid_d = 1'b1;
        if (q_entry_i.has_data) begin
          kind_d       = rilp_pkg::KindPayload;
          tag_d        = q_entry_i.tag_code;
          value_d      = q_entry_i.value_byte;
          item_end_d   = q_entry_i.item_end;
          utf8_d       = q_entry_i.text_is_utf8;
          status_d     = rilp_pkg::StatusOk;
          run_last_d   = !q_entry_i.has_status;
          sec_d        = q_entry_i.has_status;
          sec_status_d = q_entry_i.status;
        end else begin
          kind_d     = rilp_pkg::KindStatus;
          tag_d      = '0;
          value_d    = '0;
          item_end_d = 1'b0;
          utf8_d     = 1'b0;
          status_d   = q_entry_i.status;
          run_last_d = 1'b1;
        end
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sec_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sec_q   <= sec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    tag_q        <= tag_d;
    value_q      <= value_d;
    item_end_q   <= item_end_d;
    utf8_q       <= utf8_d;
    status_q     <= status_d;
    run_last_q   <= run_last_d;
    sec_status_q <= sec_status_d;
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign tag_code_o     = tag_q;
  assign value_byte_o   = value_q;
  assign item_end_o     = item_end_q;
  assign text_is_utf8_o = utf8_q;
  assign status_o       = status_q;
  assign run_last_o     = run_last_q;

  a_sec_behind_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> (valid_q && kind_q == rilp_pkg::KindPayload && !run_last_q))
    else $error("Pending status result without a payload result ahead of it.");

  a_no_pop_while_sec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sec_q |-> !q_pop_o)
    else $error("Queue popped while a status result is still pending.");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == rilp_pkg::KindStatus) |-> run_last_q)
    else $error("Status result not marked as the last of its byte.");

endmodule

// ----- rtl/riff_info_list_parser.sv -----
// Top level of the RIFF LIST/INFO chunk parser.
// The block takes one buffer byte per clock cycle while the queue is not full, and
// returns the payload bytes of every INFO sub-item tagged with its class, plus one
// status result on the byte marked as the end of the buffer. The front stage parses
// a byte in the cycle it is accepted and places what it produces in a QueueDepth-entry
// queue; the back stage drains that queue through a registered output, one result per
// cycle while out_ready_i is high. A byte's entry is written into the queue, and its
// first result is then loaded into the output register. The sustained rate is one
// byte per cycle without back-pressure, set by the single output register: a payload
// byte that is also marked as the buffer end carries a status result and so yields two
// results. After the end-of-buffer byte the parser returns to the signature phase.
module riff_info_list_parser #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       buf_end_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       kind_o,
  output logic [4:0] tag_code_o,
  output logic [7:0] value_byte_o,
  output logic       item_end_o,
  output logic       text_is_utf8_o,
  output logic [1:0] status_o,
  output logic       run_last_o
);

  rilp_pkg::entry_t push_entry;
  rilp_pkg::entry_t pop_entry;
  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;

  rilp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .buf_end_i   (buf_end_i),
    .q_full_i    (q_full),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  rilp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  rilp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_entry_i      (pop_entry),
    .q_empty_i      (q_empty),
    .q_pop_o        (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .tag_code_o     (tag_code_o),
    .value_byte_o   (value_byte_o),
    .item_end_o     (item_end_o),
    .text_is_utf8_o (text_is_utf8_o),
    .status_o       (status_o),
    .run_last_o     (run_last_o)
  );

endmodule
